>>> rtl/hours_to_calendar_date_defines.svh
// Assertion macros for the hours-to-calendar-date RTL
`ifndef HOURS_TO_CALENDAR_DATE_DEFINES_SVH
`define HOURS_TO_CALENDAR_DATE_DEFINES_SVH
`ifndef SYNTHESIS
// cons must hold in the same cycle as ante
`define HCD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcd: same-cycle check failed");
// cons must hold in the cycle after ante
`define HCD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcd: next-cycle check failed");
`else
`define HCD_ASSERT_IMP(label, ante, cons)
`define HCD_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> rtl/hcd_pkg.sv
// Shared constants and types for the hours-to-calendar-date converter
package hcd_pkg;

    // usable bits of the hour count
    localparam int HOUR_BITS = 24;

    localparam int TH_W    = 24;   // total_hours field
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;

    localparam int DAYS_W  = 20;   // whole days in the hour count
    localparam int DOE_W   = 18;   // day within a 400-year era
    localparam int YOE_W   = 9;    // year within a 400-year era

    localparam logic [TH_W-1:0] HOUR_MASK = (HOUR_BITS >= TH_W) ? {TH_W{1'b1}} :
                                            TH_W'((64'd1 << HOUR_BITS) - 64'd1);

    localparam int ERA_DAYS = 146097;

    // pipeline control into the date back end
    typedef struct packed {
        logic en;
        logic valid;
    } hcd_ctl_t;

    // fields that ride alongside the day count
    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [YEAR_W-1:0] ybase;
    } hcd_side_t;

endpackage

>>> rtl/hcd_civil.sv
// Era day to year-of-era, month and day: five-stage pipeline
module hcd_civil
    import hcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  hcd_ctl_t           ctl,
    input  logic [DOE_W-1:0]   doe,
    input  hcd_side_t          side,
    output logic               valid,
    output hcd_side_t          side_out,
    output logic [YOE_W-1:0]   yoe,
    output logic [MONTH_W-1:0] month,
    output logic [DAY_W-1:0]   day,
    output logic               jan_feb
);

    // first day of each month in a year that starts on March 1
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        unique case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // C1: leap-day corrected count, doe - doe/1460 + doe/36524 - doe/146096
    logic              c1_valid_reg;
    hcd_side_t         c1_side_reg;
    logic [DOE_W-1:0]  c1_doe_reg;
    logic [DOE_W-1:0]  c1_adj_reg;
    logic [DOE_W-1:0]  c1_adj_next;
    logic [36:0]       c1_prod;
    logic [2:0]        c1_cent;
    logic              c1_last;

    always_comb
    begin
        c1_prod = {19'd0, doe} * 37'd367720;    // /1460
        c1_cent = 3'({2'd0, doe >= 18'd36524} + {2'd0, doe >= 18'd73048} +
                     {2'd0, doe >= 18'd109572} + {2'd0, doe >= 18'd146096});
        c1_last = (doe == 18'd146096);
        c1_adj_next = doe - {10'd0, c1_prod[36:29]} + {15'd0, c1_cent} - {17'd0, c1_last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            c1_valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            c1_side_reg <= side;
            c1_doe_reg  <= doe;
            c1_adj_reg  <= c1_adj_next;
        end
    end

    // C2: year of era = adj / 365
    logic              c2_valid_reg;
    hcd_side_t         c2_side_reg;
    logic [DOE_W-1:0]  c2_doe_reg;
    logic [YOE_W-1:0]  c2_yoe_reg;
    logic [YOE_W-1:0]  c2_yoe_next;
    logic [36:0]       c2_prod;

    always_comb
    begin
        c2_prod     = {19'd0, c1_adj_reg} * 37'd367720;
        c2_yoe_next = c2_prod[35:27];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            c2_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            c2_side_reg <= c1_side_reg;
            c2_doe_reg  <= c1_doe_reg;
            c2_yoe_reg  <= c2_yoe_next;
        end
    end

    // C3: day of the March-based year
    logic              c3_valid_reg;
    hcd_side_t         c3_side_reg;
    logic [YOE_W-1:0]  c3_yoe_reg;
    logic [8:0]        c3_doy_reg;
    logic [8:0]        c3_doy_next;
    logic [15:0]       c3_prod;
    logic [DOE_W-1:0]  c3_ystart;
    logic [DOE_W-1:0]  c3_diff;

    always_comb
    begin
        c3_prod     = {9'd0, c2_yoe_reg[8:2]} * 16'd164;   // /100
        c3_ystart   = {9'd0, c2_yoe_reg} * 18'd365 + {11'd0, c2_yoe_reg[8:2]} -
                      {14'd0, c3_prod[15:12]};
        c3_diff     = c2_doe_reg - c3_ystart;
        c3_doy_next = c3_diff[8:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c3_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            c3_valid_reg <= c2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            c3_side_reg <= c2_side_reg;
            c3_yoe_reg  <= c2_yoe_reg;
            c3_doy_reg  <= c3_doy_next;
        end
    end

    // C4: March-based month index = (5*doy + 2) / 153
    logic              c4_valid_reg;
    hcd_side_t         c4_side_reg;
    logic [YOE_W-1:0]  c4_yoe_reg;
    logic [8:0]        c4_doy_reg;
    logic [3:0]        c4_mp_reg;
    logic [3:0]        c4_mp_next;
    logic [10:0]       c4_num;
    logic [22:0]       c4_prod;

    always_comb
    begin
        c4_num     = {2'd0, c3_doy_reg} * 11'd5 + 11'd2;
        c4_prod    = {12'd0, c4_num} * 23'd3427;
        c4_mp_next = c4_prod[22:19];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c4_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            c4_valid_reg <= c3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            c4_side_reg <= c3_side_reg;
            c4_yoe_reg  <= c3_yoe_reg;
            c4_doy_reg  <= c3_doy_reg;
            c4_mp_reg   <= c4_mp_next;
        end
    end

    // C5: calendar month and day
    logic               c5_valid_reg;
    hcd_side_t          c5_side_reg;
    logic [YOE_W-1:0]   c5_yoe_reg;
    logic [MONTH_W-1:0] c5_month_reg;
    logic [MONTH_W-1:0] c5_month_next;
    logic [DAY_W-1:0]   c5_day_reg;
    logic [DAY_W-1:0]   c5_day_next;
    logic               c5_jan_feb_reg;
    logic               c5_jan_feb_next;
    logic [8:0]         c5_dd;

    always_comb
    begin
        c5_dd           = c4_doy_reg - month_start(c4_mp_reg) + 9'd1;
        c5_day_next     = c5_dd[DAY_W-1:0];
        c5_jan_feb_next = (c4_mp_reg >= 4'd10);
        c5_month_next   = c5_jan_feb_next ? (c4_mp_reg - 4'd9) : (c4_mp_reg + 4'd3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c5_valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            c5_valid_reg <= c4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            c5_side_reg    <= c4_side_reg;
            c5_yoe_reg     <= c4_yoe_reg;
            c5_month_reg   <= c5_month_next;
            c5_day_reg     <= c5_day_next;
            c5_jan_feb_reg <= c5_jan_feb_next;
        end
    end

    assign valid    = c5_valid_reg;
    assign side_out = c5_side_reg;
    assign yoe      = c5_yoe_reg;
    assign month    = c5_month_reg;
    assign day      = c5_day_reg;
    assign jan_feb  = c5_jan_feb_reg;

endmodule

>>> rtl/hours_to_calendar_date.sv
// Hours-to-calendar-date converter: top level with front-end stages and output register
//
// Converts a count of whole hours since midnight on January 1 of base_year into
// the Gregorian year, month, day of month and hour of day, with full 4/100/400
// leap-year rules. The design is an 11-stage pipeline: one item may enter every
// cycle while in_ready is high, and its result passes S1..S5, C1..C5 and then
// the output register, where it is held until taken. All stages move
// together on one enable, which is low only while the output register holds a
// result that has not been taken, so in_ready falls only under back-pressure.
// base_year is written through cfg_wr_en/cfg_wr_data, resets to 2017 and must
// only change while no item is in flight; it travels with each item from entry.
// Only the low HOUR_BITS bits of total_hours are used. The year wraps to 14 bits.
`include "hours_to_calendar_date_defines.svh"

module hours_to_calendar_date
    import hcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [YEAR_W-1:0]  cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [TH_W-1:0]    total_hours,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [YEAR_W-1:0]  year,
    output logic [MONTH_W-1:0] month,
    output logic [DAY_W-1:0]   day,
    output logic [HOUR_W-1:0]  hour
);

    logic              pipe_en;
    logic [YEAR_W-1:0] base_year_reg;
    logic              out_valid_reg;

    // whole pipeline advances unless a result sits unclaimed at the output
    assign pipe_en  = !out_valid_reg || out_ready;
    assign in_ready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_year_reg <= YEAR_W'(2017);
        end
        else if (cfg_wr_en)
        begin
            base_year_reg <= cfg_wr_data;
        end
    end

    // S1: days = h/24 as (h>>3)/3 by reciprocal; base_year/400 likewise
    logic              s1_valid_reg;
    logic [TH_W-1:0]   s1_h_reg;
    logic [TH_W-1:0]   s1_h_next;
    logic [DAYS_W-1:0] s1_days_reg;
    logic [DAYS_W-1:0] s1_days_next;
    logic [YEAR_W-1:0] s1_y_reg;
    logic [5:0]        s1_qy_reg;
    logic [5:0]        s1_qy_next;
    logic [42:0]       s1_prod;
    logic [20:0]       s1_qprod;

    always_comb
    begin
        s1_h_next    = total_hours & HOUR_MASK;
        s1_prod      = {22'd0, s1_h_next[TH_W-1:3]} * 43'd2796203;
        s1_days_next = s1_prod[42:23];
        s1_qprod     = {11'd0, base_year_reg[13:4]} * 21'd1311;   // /25 after >>4
        s1_qy_next   = s1_qprod[20:15];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_h_reg    <= s1_h_next;
            s1_days_reg <= s1_days_next;
            s1_y_reg    <= base_year_reg;
            s1_qy_reg   <= s1_qy_next;
        end
    end

    // S2: hour of day from the remainder; base year within its 400-year era
    logic              s2_valid_reg;
    logic [HOUR_W-1:0] s2_hour_reg;
    logic [HOUR_W-1:0] s2_hour_next;
    logic [DAYS_W-1:0] s2_days_reg;
    logic [8:0]        s2_yc_reg;
    logic [8:0]        s2_yc_next;
    logic [5:0]        s2_qy_reg;
    logic [1:0]        s2_rem;
    logic [YEAR_W-1:0] s2_ycw;

    always_comb
    begin
        // (h>>3) - 3*days is 0..2, so two bits carry it
        s2_rem       = s1_h_reg[4:3] - 2'(s1_days_reg[1:0] * 2'd3);
        s2_hour_next = {s2_rem, s1_h_reg[2:0]};
        s2_ycw       = s1_y_reg - ({8'd0, s1_qy_reg} * 14'd400);
        s2_yc_next   = s2_ycw[8:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s2_hour_reg <= s2_hour_next;
            s2_days_reg <= s1_days_reg;
            s2_yc_reg   <= s2_yc_next;
            s2_qy_reg   <= s1_qy_reg;
        end
    end

    // S3: days from era start to base year, split as 365*yc and leap days
    logic              s3_valid_reg;
    logic [HOUR_W-1:0] s3_hour_reg;
    logic [DAYS_W-1:0] s3_days_reg;
    logic [17:0]       s3_y365_reg;
    logic [17:0]       s3_y365_next;
    logic [7:0]        s3_leaps_reg;
    logic [7:0]        s3_leaps_next;
    logic [5:0]        s3_qy_reg;
    logic [9:0]        s3_yc3;
    logic [9:0]        s3_yc99;
    logic [15:0]       s3_prod;

    always_comb
    begin
        // leap years in [0, yc): ceil(yc/4) - ceil(yc/100) + (yc != 0)
        s3_yc3        = {1'b0, s2_yc_reg} + 10'd3;
        s3_yc99       = {1'b0, s2_yc_reg} + 10'd99;
        s3_prod       = {8'd0, s3_yc99[9:2]} * 16'd164;
        s3_leaps_next = s3_yc3[9:2] - {4'd0, s3_prod[15:12]} + {7'd0, |s2_yc_reg};
        s3_y365_next  = {9'd0, s2_yc_reg} * 18'd365;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s3_hour_reg  <= s2_hour_reg;
            s3_days_reg  <= s2_days_reg;
            s3_y365_reg  <= s3_y365_next;
            s3_leaps_reg <= s3_leaps_next;
            s3_qy_reg    <= s2_qy_reg;
        end
    end

    // S4: day count from March 1 of the era before, so Jan/Feb stay positive
    logic              s4_valid_reg;
    logic [HOUR_W-1:0] s4_hour_reg;
    logic [DAYS_W-1:0] s4_n_reg;
    logic [DAYS_W-1:0] s4_n_next;
    logic [5:0]        s4_qy_reg;

    always_comb
    begin
        s4_n_next = {2'd0, s3_y365_reg} + {12'd0, s3_leaps_reg} + s3_days_reg +
                    DAYS_W'(ERA_DAYS - 60);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s4_hour_reg <= s3_hour_reg;
            s4_n_reg    <= s4_n_next;
            s4_qy_reg   <= s3_qy_reg;
        end
    end

    // S5: split into era (at most 6) and day of era by parallel compares
    logic              s5_valid_reg;
    hcd_side_t         s5_side_reg;
    hcd_side_t         s5_side_next;
    logic [DOE_W-1:0]  s5_doe_reg;
    logic [DOE_W-1:0]  s5_doe_next;
    logic [2:0]        s5_era;
    logic [DAYS_W:0]   s5_diff;

    always_comb
    begin
        s5_era      = 3'd0;
        s5_doe_next = s4_n_reg[DOE_W-1:0];
        for (int k = 1; k <= 6; k++)
        begin
            s5_diff = {1'b0, s4_n_reg} - (DAYS_W+1)'(k * ERA_DAYS);
            if (!s5_diff[DAYS_W])
            begin
                s5_era      = 3'(k);
                s5_doe_next = s5_diff[DOE_W-1:0];
            end
        end
        s5_side_next.hour  = s4_hour_reg;
        // the offset count starts one era early, hence the minus 400
        s5_side_next.ybase = ({8'd0, s4_qy_reg} + {11'd0, s5_era}) * 14'd400 - 14'd400;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s5_side_reg <= s5_side_next;
            s5_doe_reg  <= s5_doe_next;
        end
    end

    // C1..C5: year of era, month and day
    hcd_ctl_t           civ_ctl;
    logic               civ_valid;
    hcd_side_t          civ_side;
    logic [YOE_W-1:0]   civ_yoe;
    logic [MONTH_W-1:0] civ_month;
    logic [DAY_W-1:0]   civ_day;
    logic               civ_jan_feb;

    assign civ_ctl.en    = pipe_en;
    assign civ_ctl.valid = s5_valid_reg;

    hcd_civil u_civil (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (civ_ctl),
        .doe      (s5_doe_reg),
        .side     (s5_side_reg),
        .valid    (civ_valid),
        .side_out (civ_side),
        .yoe      (civ_yoe),
        .month    (civ_month),
        .day      (civ_day),
        .jan_feb  (civ_jan_feb)
    );

    // output register; January and February belong to the next March-based year
    logic [YEAR_W-1:0]  year_reg;
    logic [YEAR_W-1:0]  year_next;
    logic [MONTH_W-1:0] month_reg;
    logic [DAY_W-1:0]   day_reg;
    logic [HOUR_W-1:0]  hour_reg;

    assign year_next = civ_side.ybase + {5'd0, civ_yoe} + {13'd0, civ_jan_feb};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            out_valid_reg <= civ_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            year_reg  <= year_next;
            month_reg <= civ_month;
            day_reg   <= civ_day;
            hour_reg  <= civ_side.hour;
        end
    end

    assign out_valid = out_valid_reg;
    assign year      = year_reg;
    assign month     = month_reg;
    assign day       = day_reg;
    assign hour      = hour_reg;

    `HCD_ASSERT_IMP(a_month_range, out_valid, (month >= 4'd1) && (month <= 4'd12))
    `HCD_ASSERT_IMP(a_day_hour_range, out_valid, (day >= 5'd1) && (hour <= 5'd23))
    `HCD_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)
    `HCD_ASSERT_NXT(a_accept_enters, in_valid && in_ready, s1_valid_reg)

endmodule

>>> dv/calendar_date_checker.sv
`timescale 1ns / 1ps
// Checker for the hours-to-calendar-date converter: predicts each date and compares results
module calendar_date_checker
    import hcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [YEAR_W-1:0]  cfg_wr_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [TH_W-1:0]    total_hours,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [YEAR_W-1:0]  year,
    input  logic [MONTH_W-1:0] month,
    input  logic [DAY_W-1:0]   day,
    input  logic [HOUR_W-1:0]  hour,
    output int unsigned        errors,
    output int unsigned        pending
);

    localparam logic [YEAR_W-1:0] BASE_YEAR_AT_RESET = YEAR_W'(2017);
    localparam int unsigned DAYS_PER_ERA = 146097;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct {
        logic [TH_W-1:0]    hours;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
    } calendar_date_t;

    logic [YEAR_W-1:0] base_year_copy;
    calendar_date_t    dates_due [$];

    initial errors = 0;

    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic calendar_date_t hours_to_date(input logic [TH_W-1:0] raw,
                                                     input logic [YEAR_W-1:0] base);
        calendar_date_t d;
        int unsigned h;
        int unsigned days;
        int unsigned yr;
        int unsigned mon;
        int unsigned mlen;
        h    = int'(raw & HOUR_MASK);
        days = h / 24;
        // whole 400-year eras are the same length wherever they start
        yr   = base + 400 * (days / DAYS_PER_ERA);
        days = days % DAYS_PER_ERA;
        while (days >= (is_leap_year(yr) ? 366 : 365)) begin
            days = days - (is_leap_year(yr) ? 366 : 365);
            yr++;
        end
        mon = 1;
        mlen = MONTH_DAYS[0];
        while (days >= mlen && mon < 12) begin
            days = days - mlen;
            mon++;
            mlen = (mon == 2 && is_leap_year(yr)) ? 29 : MONTH_DAYS[mon - 1];
        end
        d.hours = raw;
        d.year  = YEAR_W'(yr);
        d.month = MONTH_W'(mon);
        d.day   = DAY_W'(days + 1);
        d.hour  = HOUR_W'(h % 24);
        return d;
    endfunction

    task automatic report_mismatch(input string what, input logic [TH_W-1:0] hrs,
                                   input int unsigned got, input int unsigned want);
        $display("%0t: %s for hours %0d: got %0d, expected %0d", $time, what, hrs, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        calendar_date_t want;
        if (!rst_n) begin
            base_year_copy <= BASE_YEAR_AT_RESET;
            dates_due.delete();
            pending <= 0;
        end
        else begin
            if (cfg_wr_en)
                base_year_copy <= cfg_wr_data;
            if (in_valid && in_ready)
                dates_due.push_back(hours_to_date(total_hours, base_year_copy));
            if (out_valid && out_ready) begin
                if (dates_due.size() == 0)
                    report_mismatch("result with none outstanding", '0, year, 0);
                else begin
                    want = dates_due.pop_front();
                    if (year !== want.year)
                        report_mismatch("year", want.hours, year, want.year);
                    if (month !== want.month)
                        report_mismatch("month", want.hours, month, want.month);
                    if (day !== want.day)
                        report_mismatch("day", want.hours, day, want.day);
                    if (hour !== want.hour)
                        report_mismatch("hour", want.hours, hour, want.hour);
                end
            end
            pending <= dates_due.size();
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Top of the hours-to-calendar-date testbench: clock, reset, stimulus, back-pressure and verdict
module tb;
    import hcd_pkg::*;

    // hours in one 400-year era; counts near multiples of it hit the era fold
    localparam int unsigned ERA_HOURS      = 146097 * 24;
    localparam int unsigned ITEMS_PER_SET  = 45;     // random items per base year
    localparam int unsigned HOLD_AFTER     = 150;    // items sent before the long hold
    localparam int unsigned LONG_HOLD      = 300;    // cycles the receiver holds off
    localparam int unsigned WATCHDOG_LIMIT = 2000;   // cycles with no item moving
    localparam int unsigned DRAIN_CYCLES   = 20;     // 11 stages, output reg included

    // hour counts for the reset base year (2017): day and year edges, the leap day
    // of 2020, the era fold, alternating bit patterns and the largest count
    localparam logic [TH_W-1:0] DIRECTED_HOURS [13] = '{
        24'd0, 24'd23, 24'd24, 24'd8759, 24'd8760,
        24'd27695, 24'd27696, 24'd27720,
        24'd3506327, 24'd3506328,
        24'hAAAAAA, 24'h555555, 24'hFFFFFF
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [YEAR_W-1:0]  cfg_wr_data;
    logic               in_valid;
    logic               in_ready;
    logic [TH_W-1:0]    total_hours;
    logic               out_valid;
    logic               out_ready;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;

    int unsigned errors;
    int unsigned pending;
    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned idle_cycles = 0;

    hours_to_calendar_date DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .total_hours (total_hours),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .year        (year),
        .month       (month),
        .day         (day),
        .hour        (hour)
    );

    calendar_date_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .total_hours (total_hours),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .year        (year),
        .month       (month),
        .day         (day),
        .hour        (hour),
        .errors      (errors),
        .pending     (pending)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Idle length shared by both sides: mostly none or short, now and then long
    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Hour count mix: full range for bit coverage, the first few years after the
    // base for month walks, the era folds, and the top of the range where the year
    // runs furthest and may wrap
    function automatic logic [TH_W-1:0] pick_hours();
        int unsigned k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                return TH_W'($urandom);
            4, 5:
                return TH_W'($urandom_range(0, 24 * 366 * 3));
            6, 7:
            begin
                k = $urandom_range(1, 4);
                return TH_W'(k * ERA_HOURS + $urandom_range(0, 96) - 48);
            end
            default:
                return 24'hFFFFFF - TH_W'($urandom_range(0, 24 * 800));
        endcase
    endfunction

    // Offer one item after a random gap and hold it until taken. Valid stays high
    // on return, so back-to-back items never drop it between them.
    task automatic send_hours(input logic [TH_W-1:0] value);
        int unsigned gap;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 19) == 0)
                burst_left = 40;
            gap = pick_idle();
        end
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid    <= 1'b0;
            total_hours <= TH_W'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        total_hours <= value;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Base year changes only with the pipeline empty; every item makes a result,
    // so an empty store of expected dates means nothing is in flight
    task automatic load_base_year(input logic [YEAR_W-1:0] value);
        release_input();
        wait (pending == 0);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Main sequence: reset, directed counts at the reset base year, then a random
    // set per base year. Bases cover the lowest legal year, year zero (a leap
    // year), a century that is not leap, one that is, the top of the legal range,
    // the largest the register holds (year wraps) and two random ones.
    initial
    begin
        logic [YEAR_W-1:0] bases [8];
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        total_hours = '0;
        bases = '{YEAR_W'(1), YEAR_W'(0), YEAR_W'(1900), YEAR_W'(2000),
                  YEAR_W'(9999), YEAR_W'(16383),
                  YEAR_W'($urandom_range(1, 9999)), YEAR_W'($urandom_range(1, 9999))};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED_HOURS[i])
            send_hours(DIRECTED_HOURS[i]);
        repeat (ITEMS_PER_SET) send_hours(pick_hours());

        foreach (bases[p])
        begin
            load_base_year(bases[p]);
            // first of March or the leap day, then the largest count
            send_hours(TH_W'(59 * 24));
            send_hours(24'hFFFFFF);
            repeat (ITEMS_PER_SET) send_hours(pick_hours());
        end

        release_input();
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random runs of ready and stalls, the odd long ready stretch, and
    // one long hold-off part way through so the pipeline fills and in_ready drops
    initial
    begin
        int unsigned run_left;
        int unsigned stall_left;
        bit          hold_done;
        out_ready  = 1'b0;
        run_left   = 0;
        stall_left = 0;
        hold_done  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && items_sent >= HOLD_AFTER)
            begin
                hold_done  = 1'b1;
                stall_left = LONG_HOLD;
            end
            else if (run_left == 0 && stall_left == 0)
            begin
                run_left   = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 12);
                stall_left = pick_idle();
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (run_left > 0)
                    run_left--;
            end
        end
    end

    // Watchdog: too long with no item moving on either side means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/hcd_pkg.sv
rtl/hcd_civil.sv
rtl/hours_to_calendar_date.sv
dv/calendar_date_checker.sv
dv/tb.sv
